[rtl/sfrx_pkg.sv]
// Package for the sync frame receiver with XOR check.
// Holds frame constants, status codes and the result struct.
// Used by sfrx_fsm, sync_frame_receiver_xor_check_unit and the testbench; no dependencies.
package sfrx_pkg;

    localparam logic [7:0] SYNC_BYTE        = 8'hAA;
    localparam logic [7:0] CMD_LOW          = 8'h30;
    localparam logic [7:0] CMD_HIGH         = 8'h44;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd16;
    localparam logic [7:0] MIN_LENGTH       = 8'd2;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_OK        = 3'd1,
        ST_CHECK_ERR = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_RESYNC    = 3'd4
    } t_status;

    // One result beat
    typedef struct packed {
        logic [7:0] length_byte;
        logic [7:0] reply_id;
        logic [7:0] command_id;
        logic [7:0] seq_byte;
        t_status    status;
    } t_result;

endpackage

[rtl/sync_frame_receiver_xor_check_unit.sv]
// Top level of the sync frame receiver with XOR check.
// Holds the max_length register and the result register; depends on sfrx_pkg, sfrx_fsm.
//
//   channel   | direction | beat content
//   ----------+-----------+----------------------------------------------------
//   s_axis    | in        | tdata[7:0] rx_byte
//   m_axis    | out       | tdata: seq_byte, command_id, reply_id, length_byte;
//             |           | tuser[2:0] status
//   cfg       | in        | i_cfg_wdata[7:0] max_length, written on i_cfg_we
//
// One byte in gives one result beat out, registered and shown in the next cycle; a byte can be taken
// every cycle, bounded only by the single result register.
// s_axis_tready is high while the result register is empty or being drained,
// so a stall on m_axis holds the pending result and blocks new bytes.
// Synchronous active-low reset clears the frame state, empties the result
// register and loads max_length with 16.
module sync_frame_receiver_xor_check_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] seq_byte, [15:8] command_id,
                                        // [23:16] reply_id, [31:24] length_byte
    output logic [2:0]  m_axis_tuser,   // [2:0] status

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata     // [7:0] max_length
);

    logic               s_beat;
    logic               r_out_valid;
    sfrx_pkg::t_result  r_out;
    sfrx_pkg::t_result  n_out;
    logic [7:0]         r_max_length;

    // accept while the result slot is free or draining this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= sfrx_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    sfrx_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s_beat),
        .i_byte       (s_axis_tdata),
        .i_max_length (r_max_length),
        .o_result     (n_out)
    );

    // result register: load on every accepted byte, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_beat) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.length_byte, r_out.reply_id,
                            r_out.command_id, r_out.seq_byte};
    assign m_axis_tuser  = r_out.status;

    a_reply_follows_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == sfrx_pkg::ST_OK
        && r_out.command_id >= sfrx_pkg::CMD_LOW
        && r_out.command_id <= sfrx_pkg::CMD_HIGH && !r_out.command_id[0]
        |-> r_out.reply_id == r_out.command_id + 8'd1)
        else $error("good frame with reply command did not set reply id");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten or dropped");

    a_short_len_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == sfrx_pkg::ST_OK
        |-> r_out.length_byte >= sfrx_pkg::MIN_LENGTH)
        else $error("good frame reported with short length");

endmodule

[rtl/sfrx_fsm.sv]
// Frame tracking state machine: phase, counters, running XOR and stored fields.
// Advances once per accepted byte and presents the result of that byte.
// Depends on sfrx_pkg.
module sfrx_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_max_length,
    output sfrx_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        PH_SYNC  = 3'd0,
        PH_SEQ   = 3'd1,
        PH_LEN   = 3'd2,
        PH_BODY  = 3'd3,
        PH_CHECK = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_reply, n_reply;
    sfrx_pkg::t_status n_status;
    logic [8:0]  cnt_inc;

    assign cnt_inc = {1'b0, r_cnt} + 9'd1;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_xor    = r_xor;
        n_seq    = r_seq;
        n_cmd    = r_cmd;
        n_reply  = r_reply;
        n_status = sfrx_pkg::ST_BUSY;
        unique case (r_phase)
            PH_SEQ: begin
                if (i_byte == sfrx_pkg::SYNC_BYTE) begin
                    n_status = sfrx_pkg::ST_RESYNC;
                    n_phase  = PH_SYNC;
                    n_cnt    = '0;
                    n_xor    = '0;
                end else begin
                    n_seq   = i_byte;
                    n_xor   = r_xor ^ i_byte;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len = i_byte;
                if (i_byte < sfrx_pkg::MIN_LENGTH) begin
                    n_status = sfrx_pkg::ST_BAD_LEN;
                    n_phase  = PH_SYNC;
                    n_cnt    = '0;
                    n_xor    = '0;
                end else begin
                    n_xor   = r_xor ^ i_byte;
                    n_cnt   = '0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_len > i_max_length) begin
                    n_status = sfrx_pkg::ST_BAD_LEN;
                    n_phase  = PH_SYNC;
                    n_cnt    = '0;
                    n_xor    = '0;
                end else begin
                    if (r_cnt == 8'd0) begin
                        n_cmd = i_byte;
                    end
                    n_xor = r_xor ^ i_byte;
                    n_cnt = cnt_inc[7:0];
                    // length counts the check byte, so the body holds length-1 bytes
                    if ((cnt_inc + 9'd1) >= {1'b0, r_len}) begin
                        n_phase = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                if (r_xor == i_byte) begin
                    n_status = sfrx_pkg::ST_OK;
                    // even command ids in range get reply id plus one
                    if (r_cmd >= sfrx_pkg::CMD_LOW && r_cmd <= sfrx_pkg::CMD_HIGH
                        && !r_cmd[0]) begin
                        n_reply = r_cmd + 8'd1;
                    end
                end else begin
                    n_status = sfrx_pkg::ST_CHECK_ERR;
                end
                n_phase = PH_SYNC;
                n_cnt   = '0;
                n_xor   = '0;
            end
            default: begin
                n_phase = PH_SYNC;
                n_cnt   = '0;
                n_xor   = '0;
                if (i_byte == sfrx_pkg::SYNC_BYTE) begin
                    n_xor   = sfrx_pkg::SYNC_BYTE;
                    n_phase = PH_SEQ;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_len   <= '0;
            r_cnt   <= '0;
            r_xor   <= '0;
            r_seq   <= '0;
            r_cmd   <= '0;
            r_reply <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_xor   <= n_xor;
            r_seq   <= n_seq;
            r_cmd   <= n_cmd;
            r_reply <= n_reply;
        end
    end

    assign o_result.status      = n_status;
    assign o_result.seq_byte    = n_seq;
    assign o_result.command_id  = n_cmd;
    assign o_result.reply_id    = n_reply;
    assign o_result.length_byte = n_len;

    a_idle_xor_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SYNC |-> r_xor == 8'd0)
        else $error("running XOR not clear while waiting for sync");

    a_body_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY || r_phase == PH_CHECK |-> r_len >= sfrx_pkg::MIN_LENGTH)
        else $error("body phase entered with short length");

    a_outcome_resyncs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && n_status != sfrx_pkg::ST_BUSY |=> r_phase == PH_SYNC)
        else $error("frame outcome did not return to sync search");

endmodule

[verif/tb_sync_frame_receiver_xor_check_unit.sv]
// Self-checking testbench for sync_frame_receiver_xor_check_unit.
// It predicts every result beat from the received bytes and checks each one field by field.
// Depends on sfrx_pkg and the RTL top level; reads no files.
module tb_sync_frame_receiver_xor_check_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat on either side before the run is abandoned. The slowest
    // correct stretch is the receiver hold-off plus a few gaps.
    localparam int WATCHDOG_LIMIT = 2000;
    // The block answers in the cycle after a byte; leave a little slack at each drain.
    localparam int DRAIN_TAIL     = 4;
    localparam int HOLD_OFF_LEN   = 200;
    localparam int RANDOM_BYTES   = 100;

    // Receiver phases of the predictor; unused codes fall back to hunting for sync.
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SEQ   = 3'd1,
        PH_LEN   = 3'd2,
        PH_BODY  = 3'd3,
        PH_CHECK = 3'd4
    } t_rx_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;      // [7:0] seq_byte, [15:8] command_id,
                                    // [23:16] reply_id, [31:24] length_byte
    logic [2:0]  m_axis_tuser;      // [2:0] status
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;       // [7:0] max_length

    sync_frame_receiver_xor_check_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Predicted frame state, kept in step with every accepted byte.
    t_rx_phase  rx_phase;
    logic [7:0] frm_len;
    logic [7:0] body_cnt;
    logic [7:0] xor_acc;
    logic [7:0] seq_val;
    logic [7:0] cmd_val;
    logic [7:0] reply_val;
    logic [7:0] max_len;

    // Predicted result beats, oldest first.
    sfrx_pkg::t_result frame_reports[$];

    // Idling controls shared by the sender, the receiver and the tests.
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold_cycles;

    // Run statistics.
    int mismatches;
    int bytes_sent;
    int frame_bytes;
    int beats_checked;
    int cfg_writes;
    int hold_offs;
    int quiet_cycles;
    int status_seen [0:4];

    // Toggle every half period.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drop back to hunting for the next sync byte.
    function automatic void restart_hunt();
        rx_phase = PH_HUNT;
        body_cnt = 8'd0;
        xor_acc  = 8'd0;
    endfunction

    // Advance the frame state by one byte and return the beat it produces.
    function automatic sfrx_pkg::t_result track_rx_byte(input logic [7:0] b);
        sfrx_pkg::t_result  res;
        sfrx_pkg::t_status  st;
        st = sfrx_pkg::ST_BUSY;
        // Bytes ignored while hunting do not count as frame traffic.
        if (rx_phase != PH_HUNT || b == sfrx_pkg::SYNC_BYTE)
            frame_bytes++;
        case (rx_phase)
            PH_SEQ: begin
                // A sync byte where the sequence belongs kills the frame; it does
                // not open a new one.
                if (b == sfrx_pkg::SYNC_BYTE) begin
                    st = sfrx_pkg::ST_RESYNC;
                    restart_hunt();
                end else begin
                    seq_val  = b;
                    xor_acc  = xor_acc ^ b;
                    rx_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                frm_len = b;
                if (b < sfrx_pkg::MIN_LENGTH) begin
                    st = sfrx_pkg::ST_BAD_LEN;
                    restart_hunt();
                end else begin
                    xor_acc  = xor_acc ^ b;
                    body_cnt = 8'd0;
                    rx_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                // The ceiling is sampled on every body byte; an oversize frame
                // swallows the byte that reveals it.
                if (frm_len > max_len) begin
                    st = sfrx_pkg::ST_BAD_LEN;
                    restart_hunt();
                end else begin
                    if (body_cnt == 8'd0)
                        cmd_val = b;
                    xor_acc  = xor_acc ^ b;
                    body_cnt = body_cnt + 8'd1;
                    if (int'(body_cnt) + 1 >= int'(frm_len))
                        rx_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (xor_acc == b) begin
                    st = sfrx_pkg::ST_OK;
                    if (cmd_val >= sfrx_pkg::CMD_LOW && cmd_val <= sfrx_pkg::CMD_HIGH
                        && !cmd_val[0])
                        reply_val = cmd_val + 8'd1;
                end else begin
                    st = sfrx_pkg::ST_CHECK_ERR;
                end
                restart_hunt();
            end
            default: begin
                restart_hunt();
                if (b == sfrx_pkg::SYNC_BYTE) begin
                    xor_acc  = sfrx_pkg::SYNC_BYTE;
                    rx_phase = PH_SEQ;
                end
            end
        endcase
        res.status      = st;
        res.seq_byte    = seq_val;
        res.command_id  = cmd_val;
        res.reply_id    = reply_val;
        res.length_byte = frm_len;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one byte, after a random gap while sender idling is on, and hold it until the block takes it.
    // Valid stays high after the beat so a gap-free next byte follows directly.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_idle_en ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        frame_reports.push_back(track_rx_byte(b));
    endtask

    // Stop offering and wait until every predicted beat has been checked.
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (frame_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Write the length ceiling with the block drained.
    task automatic write_max_length(input logic [7:0] v);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        max_len     = v;
        cfg_writes++;
    endtask

    // Build one frame. Stop early where the receiver has already dropped it:
    // resync on the sequence byte, short length, or length over the ceiling.
    task automatic send_frame(input logic [7:0] seq, input logic [7:0] len,
                              input logic [7:0] cmd, input bit bad_check);
        logic [7:0] chk;
        logic [7:0] b;
        int         k;
        chk = sfrx_pkg::SYNC_BYTE ^ seq ^ len;
        send_byte(sfrx_pkg::SYNC_BYTE);
        send_byte(seq);
        if (seq == sfrx_pkg::SYNC_BYTE)
            return;
        send_byte(len);
        if (len < sfrx_pkg::MIN_LENGTH)
            return;
        if (len > max_len) begin
            send_byte(cmd);
            return;
        end
        for (k = 1; k < int'(len); k++) begin
            b   = (k == 1) ? cmd : 8'($urandom);
            chk = chk ^ b;
            send_byte(b);
        end
        if (bad_check)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Favor command ids around the reply window so both edges get hit often.
    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 3))
            0, 1:    return sfrx_pkg::CMD_LOW + 8'(2 * $urandom_range(0, 10));
            2:       return sfrx_pkg::CMD_LOW - 8'd2 + 8'($urandom_range(0, 24));
            default: return 8'($urandom);
        endcase
    endfunction

    // One random burst: mostly well-formed frames, the rest broken ones and noise.
    task automatic send_random_burst();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  len_hi;
        logic [7:0]  len;
        pick   = $urandom_range(0, 99);
        len_hi = (max_len < 8'd10) ? max_len : 8'd10;
        if (pick < 70) begin
            // Keep frames short; now and then stretch one to the ceiling.
            if ($urandom_range(0, 19) == 0)
                len = 8'($urandom_range(2, max_len));
            else
                len = 8'($urandom_range(2, len_hi));
            send_frame(8'($urandom), len, pick_command(), $urandom_range(0, 9) == 0);
        end else if (pick < 78) begin
            if (max_len < 8'd255)
                len = 8'($urandom_range(int'(max_len) + 1, 255));
            else
                len = 8'($urandom_range(0, 1));
            send_frame(8'($urandom), len, pick_command(), 1'b0);
        end else if (pick < 84) begin
            send_frame(8'($urandom), 8'($urandom_range(0, 1)), 8'd0, 1'b0);
        end else if (pick < 90) begin
            send_frame(sfrx_pkg::SYNC_BYTE, 8'd0, 8'd0, 1'b0);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Stall a random number of cycles before each beat while receiver idling is on. A hold-off request is
    // taken up at the next beat boundary and counted out here.
    initial begin : result_sink
        int unsigned stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
                hold_offs++;
            end
            stall = rx_idle_en ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
    endtask

    // Compare each accepted beat with the oldest prediction.
    always @(posedge i_clk) begin : beat_checker
        sfrx_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked++;
            if (m_axis_tuser <= sfrx_pkg::ST_RESYNC)
                status_seen[m_axis_tuser]++;
            if (frame_reports.size() == 0) begin
                flag_mismatch("unexpected beat", 32'd0, m_axis_tdata);
            end else begin
                want = frame_reports.pop_front();
                if (m_axis_tuser !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                if (m_axis_tdata[7:0] !== want.seq_byte)
                    flag_mismatch("seq_byte", 32'(want.seq_byte),
                                  32'(m_axis_tdata[7:0]));
                if (m_axis_tdata[15:8] !== want.command_id)
                    flag_mismatch("command_id", 32'(want.command_id),
                                  32'(m_axis_tdata[15:8]));
                if (m_axis_tdata[23:16] !== want.reply_id)
                    flag_mismatch("reply_id", 32'(want.reply_id),
                                  32'(m_axis_tdata[23:16]));
                if (m_axis_tdata[31:24] !== want.length_byte)
                    flag_mismatch("length_byte", 32'(want.length_byte),
                                  32'(m_axis_tdata[31:24]));
            end
        end
    end

    // Abort when neither side moves a beat for too long.
    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no beat for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, frame_reports.size());
                $display("** sync_frame_receiver_xor_check_unit: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Noise, resync, both short lengths, a good frame opening the reply window,
    // a bad check and an oversize frame against the reset ceiling of 16.
    task automatic test_directed_cases();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(sfrx_pkg::SYNC_BYTE, 8'd0, 8'd0, 1'b0);
        send_frame(8'h00, 8'd0, 8'd0, 1'b0);
        send_frame(8'hFF, 8'd1, 8'd0, 1'b0);
        send_frame(8'h55, 8'd2, sfrx_pkg::CMD_LOW, 1'b0);
        send_frame(8'h01, 8'd2, sfrx_pkg::CMD_HIGH, 1'b1);
        send_frame(8'h02, 8'd17, 8'h00, 1'b0);
        wait_for_results();
    endtask

    // Walk the ceiling through its extremes, including the settings below two
    // where every frame is dropped.
    task automatic test_length_limits();
        write_max_length(8'd2);
        send_frame(8'h10, 8'd2, sfrx_pkg::CMD_HIGH, 1'b0);
        send_frame(8'h11, 8'd3, sfrx_pkg::CMD_LOW, 1'b0);
        write_max_length(8'd255);
        send_frame(8'h12, 8'd255, sfrx_pkg::CMD_HIGH - 8'd2, 1'b0);
        write_max_length(8'd1);
        send_frame(8'h13, 8'd2, sfrx_pkg::CMD_LOW, 1'b0);
        send_frame(8'h14, 8'd1, 8'd0, 1'b0);
        write_max_length(8'd0);
        send_frame(8'h15, 8'd2, sfrx_pkg::CMD_LOW, 1'b0);
        send_frame(8'h16, 8'd0, 8'd0, 1'b0);
        write_max_length(sfrx_pkg::MAX_LENGTH_RESET);
    endtask

    // Hold the receiver off while the sender keeps offering, so the result register fills and the input
    // stalls; then pause the sender until drained, and send more frames with sender gaps.
    task automatic test_backpressure();
        tx_idle_en     = 1'b0;
        rx_hold_cycles = HOLD_OFF_LEN;
        repeat (4) send_frame(8'($urandom), 8'd6, pick_command(), 1'b0);
        wait_for_results();
        tx_idle_en = 1'b1;
        repeat (3) send_frame(8'($urandom), 8'd4, pick_command(), 1'b0);
        wait_for_results();
    endtask

    // Random traffic over several ceilings, with idling on both sides, on one
    // side only, and not at all.
    task automatic test_random_frames();
        int         k;
        int         stop_at;
        logic [7:0] limit;
        for (k = 0; k < 5; k++) begin
            case (k)
                0:       limit = sfrx_pkg::MAX_LENGTH_RESET;
                1:       limit = 8'd6;
                2:       limit = 8'($urandom_range(3, 254));
                3:       limit = 8'd255;
                default: limit = sfrx_pkg::MIN_LENGTH;
            endcase
            write_max_length(limit);
            tx_idle_en = (k != 1 && k != 4);
            rx_idle_en = (k != 1 && k != 3);
            stop_at    = frame_bytes + RANDOM_BYTES;
            while (frame_bytes < stop_at) send_random_burst();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : test_sequence
        // Drive every input from time zero and hold reset low before the tests start.
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'd0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 8'd0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_hold_cycles = 0;
        max_len        = sfrx_pkg::MAX_LENGTH_RESET;
        frm_len        = 8'd0;
        seq_val        = 8'd0;
        cmd_val        = 8'd0;
        reply_val      = 8'd0;
        restart_hunt();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_length_limits();
        test_backpressure();
        test_random_frames();
        wait_for_results();

        if (frame_reports.size() != 0)
            flag_mismatch("results left over", 32'd0, 32'(frame_reports.size()));

        $display("Run covered %0d bytes (%0d frame bytes) over %0d ceiling settings,",
                 bytes_sent, frame_bytes, cfg_writes);
        $display("%0d hold-offs; beats: %0d checked, %0d ok, %0d check errors, %0d bad length, %0d resync",
                 hold_offs, beats_checked, status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4]);
        if (mismatches == 0) begin
            $display("** sync_frame_receiver_xor_check_unit: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** sync_frame_receiver_xor_check_unit: FAILED **");
        end
        $finish;
    end

endmodule
